/* sv/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the causal convolution and SiLU unit.
// ----------------------------------------------------------------------------
package ccs_pkg;

  typedef logic [11:0]        chan_t;
  typedef logic signed [15:0] samp_t;

  typedef enum logic {
    OP_LOAD_WEIGHT = 1'b0,
    OP_SAMPLE      = 1'b1
  } op_t;

  typedef struct packed {
    chan_t ch;
    logic  tend;
    logic  inr;
    samp_t s;
  } ccs_sum_t;

  typedef struct packed {
    chan_t ch;
    samp_t act;
    logic  tend;
  } ccs_res_t;

  localparam logic [2:0] TAPS_RESET = 3'd4;

endpackage

/* sv/ccs_in_if.sv */
// ----------------------------------------------------------------------------
// ccs_in_if
// Input word channel: weight loads and samples.
// ----------------------------------------------------------------------------
interface ccs_in_if
  import ccs_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic        operation;
  chan_t       channel;
  logic [1:0]  tap;
  samp_t       value;
  logic        token_end;

  modport source (output valid, output operation, output channel, output tap,
                  output value, output token_end, input ready);
  modport sink   (input valid, input operation, input channel, input tap,
                  input value, input token_end, output ready);
endinterface

/* sv/ccs_out_if.sv */
// ----------------------------------------------------------------------------
// ccs_out_if
// Result word channel: one activation per sample.
// ----------------------------------------------------------------------------
interface ccs_out_if
  import ccs_pkg::*;
  ();
  logic  valid;
  logic  ready;
  chan_t out_channel;
  samp_t activation;
  logic  out_token_end;

  modport source (output valid, output out_channel, output activation,
                  output out_token_end, input ready);
  modport sink   (input valid, input out_channel, input activation,
                  input out_token_end, output ready);
endinterface

/* sv/causal_conv1d_silu_unit.sv */
// ----------------------------------------------------------------------------
// causal_conv1d_silu_unit
// Per-channel causal depthwise convolution followed by SiLU, Q4.12.
//
//   port     dir  words
//   in_ch    in   weight load or sample (operation, channel, tap, value, token_end)
//   out_ch   out  one activation per sample (out_channel, activation, out_token_end)
//   cfg_*    in   taps_in_use write, no read-back
//
// One word per cycle in and out while out_ch is ready; the pipeline depth is
// set by the 25-stage sigmoid divider and the 5-stage exp polynomial.
// After reset the history memory is cleared, one channel a cycle, from
// channel 0 up to CHANNELS-1; in_ch.ready stays low meanwhile.
// Each stage holds under back-pressure and bubbles collapse, so input is taken
// while a result waits on out_ch.
// ----------------------------------------------------------------------------
module causal_conv1d_silu_unit
  import ccs_pkg::*;
#(
  parameter int CHANNELS = 4096,
  parameter int MAX_TAPS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ccs_in_if.sink      in_ch,
  ccs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  localparam int AW  = $clog2(CHANNELS);
  localparam int NH  = MAX_TAPS - 1;
  localparam int HW  = $clog2(MAX_TAPS);
  localparam int SLW = (MAX_TAPS > 2) ? $clog2(MAX_TAPS - 1) : 1;

  logic [2:0]     taps_r;
  logic [SLW-1:0] ring_slot_r;
  logic           clr_busy_r;
  logic [AW-1:0]  clr_addr_r;

  logic           acc;
  logic           is_samp;
  logic           inr;
  logic [AW-1:0]  addr;
  logic [3:0]     kl;
  logic [HW-1:0]  hist;
  logic [SLW-1:0] slot;
  logic [SLW:0]   slot_inc;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic silu_rdy;

  samp_t         val1_r;
  chan_t         ch1_r, ch2_r;
  logic          tend1_r, tend2_r;
  logic          inr1_r, inr2_r;
  logic [HW-1:0]  hist1_r;
  logic [SLW-1:0] slot1_r;
  samp_t         hrd_r [NH];
  samp_t         wrd_r [MAX_TAPS];
  logic signed [31:0] prod_r [MAX_TAPS];
  ccs_sum_t      m3_r;
  ccs_sum_t      m3_nxt;
  ccs_res_t      res;

  function automatic logic [SLW-1:0] slot_of(logic [SLW-1:0] rs, logic [HW-1:0] h);
    logic [SLW:0] r;
    r = {1'b0, rs};
    for (int i = 0; i < 8; i++) begin
      if (h != '0 && r >= (SLW+1)'(h)) begin
        r = r - (SLW+1)'(h);
      end
    end
    return (h == '0) ? '0 : r[SLW-1:0];
  endfunction

  assign acc     = in_ch.valid && in_ch.ready;
  assign is_samp = (op_t'(in_ch.operation) == OP_SAMPLE);
  assign inr     = ({20'b0, in_ch.channel} < 32'(CHANNELS));
  assign addr    = AW'(in_ch.channel);

  always_comb begin
    if (taps_r == 3'd0) begin
      kl = 4'd1;
    end else if (32'(taps_r) > MAX_TAPS) begin
      kl = 4'(MAX_TAPS);
    end else begin
      kl = {1'b0, taps_r};
    end
  end

  assign hist     = HW'(kl - 4'd1);
  assign slot     = slot_of(ring_slot_r, hist);
  assign slot_inc = {1'b0, slot} + 1'b1;

  assign rdy3        = !v3_r || silu_rdy;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1 && !clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r      <= TAPS_RESET;
      ring_slot_r <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      if (cfg_we) begin
        taps_r <= cfg_wdata;
      end
      if (acc && is_samp && in_ch.token_end && hist != '0) begin
        ring_slot_r <= (slot_inc == (SLW+1)'(hist)) ? '0 : slot_inc[SLW-1:0];
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(CHANNELS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  for (genvar j = 0; j < NH; j++) begin : g_hmem
    samp_t hmem [CHANNELS];
    always_ff @(posedge clk) begin
      if (clr_busy_r) begin
        hmem[clr_addr_r] <= '0;
      end else if (acc && is_samp && inr && hist != '0 && slot == SLW'(j)) begin
        hmem[addr] <= in_ch.value;
      end
      if (acc) begin
        hrd_r[j] <= hmem[addr];
      end
    end
  end

  for (genvar t = 0; t < MAX_TAPS; t++) begin : g_wmem
    samp_t wmem [CHANNELS];
    always_ff @(posedge clk) begin
      if (acc && !is_samp && inr && {30'b0, in_ch.tap} == t) begin
        wmem[addr] <= in_ch.value;
      end
      if (acc) begin
        wrd_r[t] <= wmem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= acc && is_samp;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      val1_r  <= in_ch.value;
      ch1_r   <= in_ch.channel;
      tend1_r <= in_ch.token_end;
      inr1_r  <= inr;
      hist1_r <= hist;
      slot1_r <= slot;
    end
  end

  always_ff @(posedge clk) begin
    logic [HW:0] lane;
    samp_t       hs;
    if (rdy2) begin
      ch2_r   <= ch1_r;
      tend2_r <= tend1_r;
      inr2_r  <= inr1_r;
      for (int kk = 0; kk < NH; kk++) begin
        lane = (HW+1)'(slot1_r) + (HW+1)'(kk);
        if (lane >= {1'b0, hist1_r}) begin
          lane = lane - {1'b0, hist1_r};
        end
        hs = '0;
        for (int j = 0; j < NH; j++) begin
          if (lane == (HW+1)'(j)) begin
            hs = hrd_r[j];
          end
        end
        prod_r[kk] <= ((HW+1)'(kk) < {1'b0, hist1_r}) ? 32'(hs) * 32'(wrd_r[kk]) : '0;
      end
      prod_r[NH] <= 32'(val1_r) * 32'(wrd_r[hist1_r]);
    end
  end

  always_comb begin
    logic signed [39:0] sum;
    logic signed [39:0] rnd;
    sum = '0;
    for (int kk = 0; kk < MAX_TAPS; kk++) begin
      sum = sum + 40'(prod_r[kk]);
    end
    rnd         = (sum + 40'sd2048) >>> 12;
    m3_nxt.ch   = ch2_r;
    m3_nxt.tend = tend2_r;
    m3_nxt.inr  = inr2_r;
    if (rnd > 40'sd32767) begin
      m3_nxt.s = 16'sh7fff;
    end else if (rnd < -40'sd32768) begin
      m3_nxt.s = 16'sh8000;
    end else begin
      m3_nxt.s = 16'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      m3_r <= m3_nxt;
    end
  end

  ccs_silu u_silu (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (silu_rdy),
    .in_data   (m3_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  assign out_ch.out_channel   = res.ch;
  assign out_ch.activation    = res.act;
  assign out_ch.out_token_end = res.tend;

  a_clr_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> $past(clr_addr_r) == AW'(CHANNELS - 1))
    else $error("history clear ended early");

  a_ring_rng: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ring_slot_r) <= ((MAX_TAPS > 2) ? MAX_TAPS - 2 : 0))
    else $error("ring slot out of range");

  a_m3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !silu_rdy |=> v3_r && $stable(m3_r))
    else $error("sum word lost under stall");

endmodule

/* sv/ccs_silu.sv */
// ----------------------------------------------------------------------------
// ccs_silu
// Pipelined SiLU: exp(-|s|) by range reduction and polynomial, sigmoid by a
// one-bit-per-stage restoring divider, then s*sigmoid with rounding.
// ----------------------------------------------------------------------------
module ccs_silu
  import ccs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ccs_sum_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ccs_res_t out_data
);

  localparam int ST_L   = 0;
  localparam int ST_NR  = 1;
  localparam int ST_H0  = 2;
  localparam int NHORN  = 5;
  localparam int ST_Y   = ST_H0 + NHORN;
  localparam int ST_E   = ST_Y + 1;
  localparam int ST_D0  = ST_E + 1;
  localparam int NDIV   = 25;
  localparam int ST_ACT = ST_D0 + NDIV;
  localparam int NST    = ST_ACT + 1;

  localparam logic signed [31:0] HC [6] = '{
    32'sd3335, 32'sd23458, 32'sd139812, 32'sd699036, 32'sd2796202, 32'sd8388608
  };
  localparam logic [24:0]        LOG2E_Q24 = 25'd24204406;
  localparam logic signed [31:0] LN2_Q24   = 32'sd11629080;
  localparam logic signed [31:0] ONE_Q24   = 32'sd16777216;
  localparam logic signed [42:0] HALF_Q36  = 43'sd34359738368;

  typedef struct packed {
    chan_t              ch;
    logic               tend;
    logic               inr;
    samp_t              s;
    logic [15:0]        a;
    logic [40:0]        m;
    logic signed [4:0]  n;
    logic signed [31:0] r;
    logic signed [31:0] sq;
    logic signed [31:0] p;
    logic [27:0]        den;
    logic [27:0]        rem;
    logic [24:0]        num;
    logic [24:0]        q;
    samp_t              act;
  } st_t;

  st_t          st_r   [NST];
  st_t          st_nxt [NST];
  st_t          st_in;
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  always_comb begin
    st_in      = '0;
    st_in.ch   = in_data.ch;
    st_in.tend = in_data.tend;
    st_in.inr  = in_data.inr;
    st_in.s    = in_data.s;
  end

  assign rdy[NST]  = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  assign out_data  = '{ch: st_r[NST-1].ch, act: st_r[NST-1].act,
                       tend: st_r[NST-1].tend};

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic vin;
    st_t  prv;

    assign rdy[k] = !v_r[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign prv = st_in;
    end else begin : g_next
      assign vin = v_r[k-1];
      assign prv = st_r[k-1];
    end

    if (k == ST_L) begin : g_l
      always_comb begin
        st_nxt[k]   = prv;
        st_nxt[k].a = prv.s[15] ? 16'(-prv.s) : 16'(prv.s);
        st_nxt[k].m = 41'(st_nxt[k].a) * 41'(LOG2E_Q24);
      end
    end else if (k == ST_NR) begin : g_nr
      logic signed [42:0] t;
      logic signed [31:0] a32;
      always_comb begin
        st_nxt[k]   = prv;
        t           = HALF_Q36 - $signed({2'b0, prv.m});
        st_nxt[k].n = 5'(t >>> 36);
        a32         = $signed({16'b0, prv.a});
        st_nxt[k].r = -(a32 <<< 12) - 32'(st_nxt[k].n * LN2_Q24);
      end
    end else if (k >= ST_H0 && k < ST_Y) begin : g_h
      logic signed [63:0] pr;
      logic signed [63:0] rr;
      always_comb begin
        st_nxt[k] = prv;
        if (k == ST_H0) begin
          pr = 64'(HC[0]) * 64'(prv.r);
        end else begin
          pr = 64'(prv.p) * 64'(prv.r);
        end
        rr          = 64'(prv.r) * 64'(prv.r);
        st_nxt[k].p = 32'(pr >>> 24) + HC[k - ST_H0 + 1];
        if (k == ST_H0) begin
          st_nxt[k].sq = 32'(rr >>> 24);
        end
      end
    end else if (k == ST_Y) begin : g_y
      logic signed [63:0] pr;
      always_comb begin
        st_nxt[k]   = prv;
        pr          = 64'(prv.p) * 64'(prv.sq);
        st_nxt[k].p = 32'(pr >>> 24) + prv.r + ONE_Q24;
      end
    end else if (k == ST_E) begin : g_e
      logic signed [31:0] e;
      logic [3:0]         sh;
      logic [27:0]        eu;
      always_comb begin
        st_nxt[k] = prv;
        sh        = 4'(-prv.n);
        e         = prv.p >>> sh;
        eu        = e[31] ? 28'd0 : 28'(e);
        st_nxt[k].den = 28'd16777216 + eu;
        st_nxt[k].q   = '0;
        if (prv.s[15]) begin
          st_nxt[k].rem = eu >> 1;
          st_nxt[k].num = {eu[0], 24'd0};
        end else begin
          st_nxt[k].rem = 28'd8388608;
          st_nxt[k].num = '0;
        end
      end
    end else if (k < ST_ACT) begin : g_d
      logic [28:0] t;
      always_comb begin
        st_nxt[k]     = prv;
        t             = {prv.rem, prv.num[24]};
        st_nxt[k].num = prv.num << 1;
        if (t >= {1'b0, prv.den}) begin
          st_nxt[k].rem = 28'(t - {1'b0, prv.den});
          st_nxt[k].q   = {prv.q[23:0], 1'b1};
        end else begin
          st_nxt[k].rem = t[27:0];
          st_nxt[k].q   = {prv.q[23:0], 1'b0};
        end
      end
    end else begin : g_act
      logic signed [47:0] pr;
      logic signed [47:0] rd;
      always_comb begin
        st_nxt[k] = prv;
        pr        = 48'(prv.s) * $signed({23'b0, prv.q});
        rd        = (pr + 48'sd8388608) >>> 24;
        if (!prv.inr) begin
          st_nxt[k].act = '0;
        end else if (rd > 48'sd32767) begin
          st_nxt[k].act = 16'sh7fff;
        end else if (rd < -48'sd32768) begin
          st_nxt[k].act = 16'sh8000;
        end else begin
          st_nxt[k].act = 16'(rd);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !out_ready |=> v_r[NST-1] && $stable(st_r[NST-1]))
    else $error("stalled result changed");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !st_r[NST-1].inr |-> st_r[NST-1].act == 16'sd0)
    else $error("out-of-range channel gave nonzero activation");

  a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_ACT-1] |-> st_r[ST_ACT-1].q <= 25'd16777216)
    else $error("sigmoid quotient above one");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for causal_conv1d_silu_unit. A short table of weight
// loads and samples runs first, followed by random traffic over a pool of
// preloaded channels under every kernel length setting. Each activation is
// checked against a local fixed-point model of the convolution and the SiLU,
// while the sender bursts and the receiver stalls, including one long hold-off.
// ----------------------------------------------------------------------------
module testbench
  import ccs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NCH        = 4096;
  localparam int  NTAP       = 4;
  localparam int  DRAIN_WAIT = 60;
  localparam int  HOLD_LEN   = 400;
  localparam int  PHASE_LEN  = 175;
  localparam longint ONE_Q24 = 64'sd16777216;

  typedef struct {
    op_t         op;
    chan_t       ch;
    logic [1:0]  tap;
    samp_t       val;
    logic        tend;
    logic        typed;
    samp_t       act;
  } word_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  ccs_in_if  in_ch ();
  ccs_out_if out_ch ();

  causal_conv1d_silu_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  samp_t     weights [NTAP][NCH];
  samp_t     history [NTAP-1][NCH];
  int        ring_pos;
  logic [2:0] kernel_len;

  ccs_res_t  act_queue[$];
  chan_t     pool[$];
  int        mismatches;
  int        samples_sent, loads_sent, results_seen;
  int        burst_left;
  int        stall_mode;
  bit        hold_req;

  function automatic samp_t sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return samp_t'(v);
  endfunction

  function automatic samp_t silu_q12(longint s);
    longint coef [6] = '{3335, 23458, 139812, 699036, 2796202, 8388608};
    longint a, n, r, p, sq, y, e;
    longint unsigned den, sig;
    int k;
    a = (s < 0) ? -s : s;
    n = (-a * 64'sd24204406 + (64'sd1 <<< 35)) >>> 36;
    r = -a * 4096 - n * 64'sd11632640 - n * (-64'sd3560);
    p = coef[0];
    for (int i = 1; i < 6; i++) p = ((p * r) >>> 24) + coef[i];
    sq = (r * r) >>> 24;
    y  = ((p * sq) >>> 24) + r + ONE_Q24;
    k  = (n < -62) ? 62 : int'(-n);
    e  = y >>> k;
    if (e < 0) e = 0;
    den = longint'(ONE_Q24) + e;
    if (s >= 0) sig = (64'd1 << 48) / den;
    else        sig = (longint'(e) << 24) / den;
    return sat16((s * longint'(sig) + (64'sd1 <<< 23)) >>> 24);
  endfunction

  function automatic bit conv_predict(op_t op, chan_t ch, logic [1:0] tap, samp_t val,
                                      logic tend, output ccs_res_t res);
    int kl, nh, slot;
    longint sum;
    if (op == OP_LOAD_WEIGHT) begin
      weights[tap][ch] = val;
      return 1'b0;
    end
    kl = (kernel_len < 1) ? 1 : (kernel_len > NTAP) ? NTAP : kernel_len;
    nh = kl - 1;
    slot = (nh != 0) ? ring_pos % nh : 0;
    sum = longint'(val) * weights[nh][ch];
    for (int j = 0; j < nh; j++)
      sum += longint'(history[(slot + j) % nh][ch]) * weights[j][ch];
    if (nh != 0) history[slot][ch] = val;
    res.ch = ch;
    res.act = silu_q12(sat16((sum + 2048) >>> 12));
    res.tend = tend;
    if (tend && nh != 0) ring_pos = (slot + 1) % nh;
    return 1'b1;
  endfunction

  task automatic send_word(op_t op, chan_t ch, logic [1:0] tap, samp_t val, logic tend,
                           bit typed = 0, samp_t act = '0);
    ccs_res_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.channel   <= ch;
    in_ch.tap       <= tap;
    in_ch.value     <= val;
    in_ch.token_end <= tend;
    do @(posedge clk); while (!in_ch.ready);
    if (conv_predict(op, ch, tap, val, tend, res)) begin
      if (typed) res.act = act;
      act_queue.push_back(res);
      samples_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  task automatic drain_and_idle();
    in_ch.valid <= 1'b0;
    while (act_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_taps(logic [2:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    kernel_len = v;
    @(posedge clk);
  endtask

  function automatic samp_t pick_value();
    case ($urandom_range(0, 5))
      0:       return samp_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1, 2:    return samp_t'($urandom_range(0, 8191) - 4096);
      default: return samp_t'($urandom);
    endcase
  endfunction

  task automatic random_word();
    chan_t ch;
    ch = pool[$urandom_range(0, pool.size() - 1)];
    if ($urandom_range(0, 99) < 82)
      send_word(OP_SAMPLE, ch, 2'($urandom), pick_value(), $urandom_range(0, 3) == 0);
    else
      send_word(OP_LOAD_WEIGHT, ch, 2'($urandom), pick_value(), 1'($urandom));
  endtask

  // receiver: check, then choose next ready
  initial begin
    int hold_cnt;
    logic [15:0] pattern;
    ccs_res_t want;
    hold_cnt = 0;
    pattern = 16'hffff;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (act_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: ch %0d act %0d tend %0d",
                     out_ch.out_channel, out_ch.activation, out_ch.out_token_end);
        end else begin
          want = act_queue.pop_front();
          if (out_ch.out_channel !== want.ch || out_ch.activation !== want.act ||
              out_ch.out_token_end !== want.tend) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ch %0d act %0d tend %0d, got ch %0d act %0d tend %0d",
                       want.ch, want.act, want.tend, out_ch.out_channel,
                       out_ch.activation, out_ch.out_token_end);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_LEN;
      end
      if ($urandom_range(0, 63) == 0) pattern = 16'($urandom);
      pattern = {pattern[14:0], pattern[15]};
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= pattern[0];
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    word_row_t rows [$];
    logic [2:0] lens [8] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};
    mismatches = 0; samples_sent = 0; loads_sent = 0; results_seen = 0;
    burst_left = 0; stall_mode = 0; hold_req = 0;
    ring_pos = 0; kernel_len = TAPS_RESET;
    foreach (history[i, j]) history[i][j] = '0;
    in_ch.valid <= 1'b0; in_ch.operation <= OP_LOAD_WEIGHT; in_ch.channel <= '0;
    in_ch.tap <= '0; in_ch.value <= '0; in_ch.token_end <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_taps(3'd4);

    rows = '{
      '{OP_LOAD_WEIGHT, 12'd0,    2'd0, 16'sh0000, 1'b0, 1'b0, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd0,    2'd1, 16'sh0000, 1'b1, 1'b0, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd0,    2'd2, 16'sh0000, 1'b0, 1'b0, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd0,    2'd3, 16'sh0000, 1'b1, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd0,    2'd0, 16'sh7fff, 1'b0, 1'b1, 16'sh0},
      '{OP_SAMPLE,      12'd0,    2'd3, 16'sh8000, 1'b1, 1'b1, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd4095, 2'd0, 16'sh7fff, 1'b0, 1'b0, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd4095, 2'd1, 16'sh8000, 1'b0, 1'b0, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd4095, 2'd2, 16'sh7fff, 1'b0, 1'b0, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd4095, 2'd3, 16'sh7fff, 1'b0, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd4095, 2'd0, 16'sh7fff, 1'b0, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd4095, 2'd0, 16'sh8000, 1'b0, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd4095, 2'd1, 16'sh0000, 1'b1, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd4095, 2'd2, 16'sh1000, 1'b1, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd4095, 2'd0, -16'sh1000, 1'b0, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd4095, 2'd3, 16'sh0800, 1'b1, 1'b0, 16'sh0},
      '{OP_LOAD_WEIGHT, 12'd4095, 2'd3, 16'sh1000, 1'b0, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd4095, 2'd0, -16'sh0800, 1'b1, 1'b0, 16'sh0},
      '{OP_SAMPLE,      12'd0,    2'd0, 16'sh1234, 1'b1, 1'b1, 16'sh0}
    };
    foreach (rows[i])
      send_word(rows[i].op, rows[i].ch, rows[i].tap, rows[i].val, rows[i].tend,
                rows[i].typed, rows[i].act);

    pool = '{12'd0, 12'd4095};
    for (int b = 0; b < 12; b++) pool.push_back(chan_t'(1 << b));
    repeat (10) pool.push_back(chan_t'($urandom));
    foreach (pool[i])
      for (int t = 0; t < NTAP; t++)
        send_word(OP_LOAD_WEIGHT, pool[i], 2'(t), pick_value(), 1'($urandom));

    foreach (lens[p]) begin
      drain_and_idle();
      write_taps(lens[p]);
      stall_mode = p % 3;
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 3 && i == 20) hold_req = 1;
        random_word();
      end
    end
    drain_and_idle();

    $display("covered %0d samples and %0d weight loads over %0d channels,",
             samples_sent, loads_sent, pool.size());
    $display("kernel lengths 0..7, %0d activations checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && act_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
